### hdl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master: shared definitions
// Command codes, sequencer phases, configuration indexes, reset values and
// the structs that travel between the modules of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cram_pkg;

  // Command codes carried in the op field of an input word.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_WRITE8  = 3'd1,
    OP_WRITE16 = 3'd2,
    OP_READ8   = 3'd3,
    OP_READ16  = 3'd4
  } op_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd1;

  // Configuration reset values.
  localparam logic [6:0]  DEV_ADDR_RESET    = 7'd41;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd2000;

  // Number of bits in one bus byte.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Bus sequencer phases, one quarter-bit step each.
  typedef enum logic [17:0] {
    PH_IDLE      = 18'b000000000000000001,
    PH_ST1       = 18'b000000000000000010,
    PH_ST2       = 18'b000000000000000100,
    PH_ST3       = 18'b000000000000001000,
    PH_TX_DATA   = 18'b000000000000010000,
    PH_TX_HIGH   = 18'b000000000000100000,
    PH_TX_LOW    = 18'b000000000001000000,
    PH_ACK_REL   = 18'b000000000010000000,
    PH_ACK_HIGH  = 18'b000000000100000000,
    PH_ACK_WAIT  = 18'b000000001000000000,
    PH_RX_FIRST  = 18'b000000010000000000,
    PH_RX_HIGH   = 18'b000000100000000000,
    PH_RX_SAMPLE = 18'b000001000000000000,
    PH_RA_HIGH   = 18'b000010000000000000,
    PH_RA_LOW    = 18'b000100000000000000,
    PH_SP1       = 18'b001000000000000000,
    PH_SP2       = 18'b010000000000000000,
    PH_SP3       = 18'b100000000000000000
  } phase_e;

  // Byte positions within a transaction.
  localparam logic [2:0] BYTE_REGISTER = 3'd1;
  localparam logic [2:0] BYTE_SECOND   = 3'd2;
  localparam logic [2:0] BYTE_THIRD    = 3'd3;
  localparam logic [2:0] BYTE_LAST     = 3'd4;

  // Live configuration values.
  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] ack_timeout;
  } cfg_t;

  // Result word of one input word.
  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy;
    logic        done;
    logic        nack_error;
    logic [15:0] read_data;
  } seq_result_t;

endpackage

`default_nettype wire

### hdl/i2cram_cfg.sv
// ----------------------------------------------------------------------------
// I2C register access master: configuration registers
// Holds the device address and the ACK timeout, written through a
// valid/ready write channel that never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  output i2cram_pkg::cfg_t       cfg_o
);
  import i2cram_pkg::*;

  logic [6:0]  dev_addr_q;
  logic [15:0] ack_timeout_q;

  // A write to an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RESET;
      ack_timeout_q <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DEVICE_ADDRESS) begin
        dev_addr_q <= cfg_data_i[6:0];
      end else if (cfg_index_i == CFG_ACK_TIMEOUT) begin
        ack_timeout_q <= cfg_data_i;
      end
    end
  end

  assign cfg_o.dev_addr    = dev_addr_q;
  assign cfg_o.ack_timeout = ack_timeout_q;

endmodule

`default_nettype wire

### hdl/i2cram_seq.sv
// ----------------------------------------------------------------------------
// I2C register access master: bus sequencer
// Holds the transaction state and moves it one quarter-bit step for each
// tick word, or starts a transaction on a command word while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cram_seq (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  wire logic [2:0]             op_i,
  input  wire logic [7:0]             reg_addr_i,
  input  wire logic [15:0]            write_data_i,
  input  wire logic                   sda_in_i,
  input  wire i2cram_pkg::cfg_t       cfg_i,
  output i2cram_pkg::seq_result_t     result_o
);
  import i2cram_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_count_q, bit_count_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  byte_idx_q, byte_idx_d;
  logic [15:0] ack_cnt_q, ack_cnt_d;
  op_e         cmd_q, cmd_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] wval_q, wval_d;
  logic [15:0] rval_q, rval_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        err_q, err_d;
  logic        done;
  logic        more_read;
  logic        is_cmd;
  logic        is_read;
  logic [2:0]  byte_idx_inc;
  logic [3:0]  bit_count_inc;

  assign is_cmd        = op_i inside {[OP_WRITE8:OP_READ16]};
  assign more_read     = (cmd_q == OP_READ16) && (byte_idx_q == BYTE_THIRD);
  assign is_read       = (cmd_q == OP_READ8) || (cmd_q == OP_READ16);
  assign byte_idx_inc  = byte_idx_q + 3'd1;
  assign bit_count_inc = bit_count_q + 4'd1;

  // Next state for one accepted word.
  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    byte_idx_d  = byte_idx_q;
    ack_cnt_d   = ack_cnt_q;
    cmd_d       = cmd_q;
    reg_d       = reg_q;
    wval_d      = wval_q;
    rval_d      = rval_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    err_d       = err_q;
    done        = 1'b0;

    if (step_i && is_cmd) begin
      // Start a transaction; a command while busy is dropped.
      if (phase_q == PH_IDLE) begin
        cmd_d       = op_e'(op_i);
        reg_d       = reg_addr_i;
        wval_d      = write_data_i;
        rval_d      = '0;
        bit_count_d = '0;
        byte_idx_d  = '0;
        ack_cnt_d   = '0;
        err_d       = 1'b0;
        shift_d     = {cfg_i.dev_addr, 1'b0};
        phase_d     = PH_ST1;
      end
    end else if (step_i && (op_i == OP_TICK) && (phase_q != PH_IDLE)) begin
      case (phase_q)
        PH_ST1: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          phase_d = PH_ST2;
        end
        PH_ST2: begin
          sda_d   = 1'b0;
          phase_d = PH_ST3;
        end
        PH_ST3: begin
          scl_d       = 1'b0;
          bit_count_d = '0;
          phase_d     = PH_TX_DATA;
        end
        PH_TX_DATA: begin
          scl_d   = 1'b0;
          sda_d   = shift_q[7];
          phase_d = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_d   = 1'b1;
          phase_d = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          scl_d       = 1'b0;
          shift_d     = {shift_q[6:0], 1'b0};
          bit_count_d = bit_count_inc;
          phase_d     = (bit_count_inc >= BITS_PER_BYTE) ? PH_ACK_REL : PH_TX_DATA;
        end
        PH_ACK_REL: begin
          sda_d   = 1'b1;
          phase_d = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          scl_d     = 1'b1;
          ack_cnt_d = '0;
          phase_d   = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          if (!sda_in_i) begin
            // Acknowledged: pick the next byte of the transaction.
            scl_d      = 1'b0;
            byte_idx_d = byte_idx_inc;
            if (byte_idx_inc == BYTE_REGISTER) begin
              shift_d     = reg_q;
              bit_count_d = '0;
              phase_d     = PH_TX_DATA;
            end else if (byte_idx_inc == BYTE_SECOND) begin
              if (cmd_q == OP_WRITE8) begin
                shift_d     = wval_q[7:0];
                bit_count_d = '0;
                phase_d     = PH_TX_DATA;
              end else if (cmd_q == OP_WRITE16) begin
                shift_d     = wval_q[15:8];
                bit_count_d = '0;
                phase_d     = PH_TX_DATA;
              end else begin
                // Repeated start with the read address byte.
                shift_d = {cfg_i.dev_addr, 1'b1};
                phase_d = PH_ST1;
              end
            end else if (byte_idx_inc == BYTE_THIRD) begin
              if (cmd_q == OP_WRITE8) begin
                phase_d = PH_SP1;
              end else if (cmd_q == OP_WRITE16) begin
                shift_d     = wval_q[7:0];
                bit_count_d = '0;
                phase_d     = PH_TX_DATA;
              end else begin
                phase_d = PH_RX_FIRST;
              end
            end else begin
              phase_d = PH_SP1;
            end
          end else if (ack_cnt_q >= cfg_i.ack_timeout) begin
            // Timeout: pull SDA low under high SCL, then finish the stop.
            sda_d   = 1'b0;
            err_d   = 1'b1;
            phase_d = PH_SP2;
          end else begin
            ack_cnt_d = ack_cnt_q + 16'd1;
          end
        end
        PH_RX_FIRST: begin
          sda_d       = 1'b1;
          scl_d       = 1'b0;
          bit_count_d = '0;
          shift_d     = '0;
          phase_d     = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          scl_d       = 1'b1;
          bit_count_d = bit_count_inc;
          phase_d     = PH_RX_SAMPLE;
        end
        PH_RX_SAMPLE: begin
          shift_d = {shift_q[6:0], sda_in_i};
          scl_d   = 1'b0;
          if (bit_count_q >= BITS_PER_BYTE) begin
            // Master ACK on all but the last byte.
            sda_d   = !more_read;
            phase_d = PH_RA_HIGH;
          end else begin
            phase_d = PH_RX_HIGH;
          end
        end
        PH_RA_HIGH: begin
          scl_d   = 1'b1;
          phase_d = PH_RA_LOW;
        end
        PH_RA_LOW: begin
          scl_d  = 1'b0;
          rval_d = {rval_q[7:0], shift_q};
          if (more_read) begin
            byte_idx_d = BYTE_LAST;
            phase_d    = PH_RX_FIRST;
          end else begin
            phase_d = PH_SP1;
          end
        end
        PH_SP1: begin
          sda_d   = 1'b0;
          phase_d = PH_SP2;
        end
        PH_SP2: begin
          scl_d   = 1'b1;
          phase_d = PH_SP3;
        end
        PH_SP3: begin
          sda_d   = 1'b1;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= '0;
      byte_idx_q  <= '0;
      ack_cnt_q   <= '0;
      cmd_q       <= OP_TICK;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      err_q       <= 1'b0;
      shift_q     <= '0;
      reg_q       <= '0;
      wval_q      <= '0;
      rval_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      byte_idx_q  <= byte_idx_d;
      ack_cnt_q   <= ack_cnt_d;
      cmd_q       <= cmd_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      err_q       <= err_d;
      shift_q     <= shift_d;
      reg_q       <= reg_d;
      wval_q      <= wval_d;
      rval_q      <= rval_d;
    end
  end

  // Result word seen after this step.
  assign result_o.scl_level  = scl_d;
  assign result_o.sda_level  = sda_d;
  assign result_o.busy       = (phase_d != PH_IDLE);
  assign result_o.done       = done;
  assign result_o.nack_error = done && err_d;
  assign result_o.read_data  = (done && !err_d && is_read) ? rval_d : 16'd0;

endmodule

`default_nettype wire

### hdl/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// I2C register access master
// Bit-level I2C master for one-byte-addressed device registers.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o) takes one word per cycle:
//   either a command (write8, write16, read8, read16) that starts a
//   transaction while idle, or a tick that moves the bus one quarter bit
//   and carries the sampled SDA level. Every word yields exactly one result
//   word on the output channel (out_valid_o/out_ready_i) with the SCL and
//   SDA drive levels, busy, done, the NACK timeout flag and read data.
//   A word passes from the input register through the sequencer step into
//   the result register. Throughput is one word per cycle while the
//   receiver takes every result and the sender offers a word.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; then in_ready_o drops until a result is taken.
//   The configuration channel (cfg_valid_i/cfg_ready_o) is always ready and
//   unchecked; the user must write it only while no transaction is running.
//   Reset leaves the bus idle with both lines released high, the device
//   address at 41 and the ACK timeout at 2000 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_access_master (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Input word channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  reg_addr_i,
  input  wire logic [15:0] write_data_i,
  input  wire logic        sda_in_i,
  // Result word channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             scl_level_o,
  output logic             sda_level_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic             nack_error_o,
  output logic [15:0]      read_data_o
);
  import i2cram_pkg::*;

  cfg_t        cfg;
  seq_result_t result;
  seq_result_t out_q;
  logic        in_valid_q;
  logic [2:0]  op_q;
  logic [7:0]  reg_addr_q;
  logic [15:0] write_data_q;
  logic        sda_in_q;
  logic        out_valid_q;
  logic        advance;

  assign cfg_ready_o = 1'b1;

  // A buffered word moves on when the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q         <= op_i;
      reg_addr_q   <= reg_addr_i;
      write_data_q <= write_data_i;
      sda_in_q     <= sda_in_i;
    end
  end

  i2cram_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2cram_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .op_i         (op_q),
    .reg_addr_i   (reg_addr_q),
    .write_data_i (write_data_q),
    .sda_in_i     (sda_in_q),
    .cfg_i        (cfg),
    .result_o     (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_level_o  = out_q.scl_level;
  assign sda_level_o  = out_q.sda_level;
  assign busy_res_o   = out_q.busy;
  assign done_res_o   = out_q.done;
  assign nack_error_o = out_q.nack_error;
  assign read_data_o  = out_q.read_data;

endmodule

`default_nettype wire

### verif/i2c_register_access_master_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Streams command and tick words into the block under several address,
// timeout and flow-control settings. A predictor follows the bus sequencer
// one word at a time. Every result word is checked field by field against
// the prediction. Stimulus is shaped from a second copy of the predictor so
// that ACKs, read data bits and timeouts land where the sequencer samples
// SDA.
// ----------------------------------------------------------------------------

module i2c_register_access_master_test;
  import i2cram_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_CYCLES     = 300;
  localparam int WORDS_PER_PHASE = 60;
  localparam int PHASE_COUNT     = 8;
  localparam int PRESSURE_PHASE  = 4;
  localparam int MAX_PRINTS      = 20;

  // Read data bit patterns that the stimulus puts on SDA.
  localparam int RX_ZEROS  = 0;
  localparam int RX_ONES   = 1;
  localparam int RX_RANDOM = 2;

  // Op codes that the block does not define.
  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

  // One input word as it travels through the queue.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  reg_addr;
    logic [15:0] wdata;
    logic        sda;
  } bus_word_t;

  // Sequencer state of the predictor.
  typedef struct packed {
    phase_e      ph;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [2:0]  byte_idx;
    logic [15:0] wait_cnt;
    logic [2:0]  cmd;
    logic [7:0]  regno;
    logic [15:0] wval;
    logic [15:0] rval;
    logic        scl;
    logic        sda;
    logic        err;
  } bus_state_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_valid_i  = 1'b0;
  logic [1:0]  cfg_index_i  = CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic [2:0]  op_i         = OP_TICK;
  logic [7:0]  reg_addr_i   = '0;
  logic [15:0] write_data_i = '0;
  logic        sda_in_i     = 1'b1;
  logic        out_ready_i  = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        scl_level_o;
  logic        sda_level_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        nack_error_o;
  logic [15:0] read_data_o;

  // Live configuration, written only by the stimulus process.
  logic [6:0]  cfg_dev = DEV_ADDR_RESET;
  logic [15:0] cfg_tmo = ACK_TIMEOUT_RESET;

  bus_word_t   bus_words[$];
  seq_result_t bus_outcomes[$];
  bus_state_t  bus_ref;
  bus_state_t  bus_shape;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit pressure_mode  = 1'b0;
  bit hold_used      = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int n_mismatch     = 0;
  int n_checked      = 0;
  int n_counted      = 0;

  i2c_register_access_master uut (.*);

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bus idle after reset: both lines released high.
  function automatic bus_state_t bus_idle();
    bus_state_t s;
    s     = '0;
    s.ph  = PH_IDLE;
    s.scl = 1'b1;
    s.sda = 1'b1;
    return s;
  endfunction

  // Advances the sequencer by one word and forms the result word.
  function automatic bus_state_t i2c_next(input bus_state_t cur, input bus_word_t w,
                                          input logic [6:0] dev, input logic [15:0] tmo,
                                          output seq_result_t res);
    bus_state_t s;
    logic       done;
    logic       load;
    logic [7:0] load_byte;
    logic       more;
    s         = cur;
    done      = 1'b0;
    load      = 1'b0;
    load_byte = '0;
    // A second read byte follows only in read16, after the first one.
    more = (s.cmd == OP_READ16) && (s.byte_idx == BYTE_THIRD);
    if (w.op >= OP_WRITE8 && w.op <= OP_READ16) begin
      // Commands start a transaction only while idle.
      if (s.ph == PH_IDLE) begin
        s.cmd      = w.op;
        s.regno    = w.reg_addr;
        s.wval     = w.wdata;
        s.rval     = '0;
        s.bit_cnt  = '0;
        s.byte_idx = '0;
        s.wait_cnt = '0;
        s.err      = 1'b0;
        s.shreg    = {dev, 1'b0};
        s.ph       = PH_ST1;
      end
    end else if (w.op == OP_TICK && s.ph != PH_IDLE) begin
      case (s.ph)
        PH_ST1: begin
          s.scl = 1'b1;
          s.sda = 1'b1;
          s.ph  = PH_ST2;
        end
        PH_ST2: begin
          s.sda = 1'b0;
          s.ph  = PH_ST3;
        end
        PH_ST3: begin
          s.scl     = 1'b0;
          s.bit_cnt = '0;
          s.ph      = PH_TX_DATA;
        end
        PH_TX_DATA: begin
          s.scl = 1'b0;
          s.sda = s.shreg[7];
          s.ph  = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          s.scl = 1'b1;
          s.ph  = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          s.scl     = 1'b0;
          s.shreg   = {s.shreg[6:0], 1'b0};
          s.bit_cnt = s.bit_cnt + 4'd1;
          s.ph      = (s.bit_cnt >= BITS_PER_BYTE) ? PH_ACK_REL : PH_TX_DATA;
        end
        PH_ACK_REL: begin
          s.sda = 1'b1;
          s.ph  = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          s.scl      = 1'b1;
          s.wait_cnt = '0;
          s.ph       = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          if (!w.sda) begin
            // Acknowledged: pick the next byte or the next bus step.
            s.scl      = 1'b0;
            s.byte_idx = s.byte_idx + 3'd1;
            case (s.byte_idx)
              BYTE_REGISTER: begin
                load      = 1'b1;
                load_byte = s.regno;
              end
              BYTE_SECOND: begin
                if (s.cmd == OP_WRITE8) begin
                  load      = 1'b1;
                  load_byte = s.wval[7:0];
                end else if (s.cmd == OP_WRITE16) begin
                  load      = 1'b1;
                  load_byte = s.wval[15:8];
                end else begin
                  s.shreg = {dev, 1'b1};
                  s.ph    = PH_ST1;
                end
              end
              BYTE_THIRD: begin
                if (s.cmd == OP_WRITE8) begin
                  s.ph = PH_SP1;
                end else if (s.cmd == OP_WRITE16) begin
                  load      = 1'b1;
                  load_byte = s.wval[7:0];
                end else begin
                  s.ph = PH_RX_FIRST;
                end
              end
              default: s.ph = PH_SP1;
            endcase
            if (load) begin
              s.shreg   = load_byte;
              s.bit_cnt = '0;
              s.ph      = PH_TX_DATA;
            end
          end else if (s.wait_cnt >= tmo) begin
            // Timeout: stop condition from the SCL-high state.
            s.sda = 1'b0;
            s.err = 1'b1;
            s.ph  = PH_SP2;
          end else begin
            s.wait_cnt = s.wait_cnt + 16'd1;
          end
        end
        PH_RX_FIRST: begin
          s.sda     = 1'b1;
          s.scl     = 1'b0;
          s.bit_cnt = '0;
          s.shreg   = '0;
          s.ph      = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          s.scl     = 1'b1;
          s.bit_cnt = s.bit_cnt + 4'd1;
          s.ph      = PH_RX_SAMPLE;
        end
        PH_RX_SAMPLE: begin
          s.shreg = {s.shreg[6:0], w.sda};
          s.scl   = 1'b0;
          if (s.bit_cnt >= BITS_PER_BYTE) begin
            s.sda = !more;
            s.ph  = PH_RA_HIGH;
          end else begin
            s.ph = PH_RX_HIGH;
          end
        end
        PH_RA_HIGH: begin
          s.scl = 1'b1;
          s.ph  = PH_RA_LOW;
        end
        PH_RA_LOW: begin
          s.scl  = 1'b0;
          s.rval = {s.rval[7:0], s.shreg};
          if (more) begin
            s.byte_idx = BYTE_LAST;
            s.ph       = PH_RX_FIRST;
          end else begin
            s.ph = PH_SP1;
          end
        end
        PH_SP1: begin
          s.sda = 1'b0;
          s.ph  = PH_SP2;
        end
        PH_SP2: begin
          s.scl = 1'b1;
          s.ph  = PH_SP3;
        end
        PH_SP3: begin
          s.sda = 1'b1;
          s.ph  = PH_IDLE;
          done  = 1'b1;
        end
        default: s.ph = PH_IDLE;
      endcase
    end
    res.scl_level  = s.scl;
    res.sda_level  = s.sda;
    res.busy       = (s.ph != PH_IDLE);
    res.done       = done;
    res.nack_error = done && s.err;
    res.read_data  = (done && !s.err && s.cmd >= OP_READ8) ? s.rval : 16'h0000;
    return s;
  endfunction

  // Queues one word and moves the shaping copy of the sequencer along.
  task automatic offer(input logic [2:0] op, input logic [7:0] ra, input logic [15:0] wd,
                       input logic sda);
    bus_word_t   w;
    seq_result_t unused;
    w.op       = op;
    w.reg_addr = ra;
    w.wdata    = wd;
    w.sda      = sda;
    // Words the block ignores do not count toward the phase length.
    if (!((op == OP_TICK && bus_shape.ph == PH_IDLE) || op > OP_READ16 ||
          (op != OP_TICK && bus_shape.ph != PH_IDLE))) begin
      n_counted++;
    end
    bus_shape = i2c_next(bus_shape, w, cfg_dev, cfg_tmo, unused);
    bus_words.push_back(w);
  endtask

  // One command followed by ticks until the bus is idle again.
  // hold_pct is the chance that SDA stays high on an ACK wait tick.
  task automatic run_txn(input logic [2:0] op, input logic [7:0] ra, input logic [15:0] wd,
                         input int rx_mode, input int hold_pct, input int noise_pct);
    logic sda;
    offer(op, ra, wd, 1'($urandom));
    while (bus_shape.ph != PH_IDLE) begin
      // Occasional command or undefined op that must be ignored mid-transfer.
      if (int'($urandom_range(99)) < noise_pct) begin
        offer(3'($urandom_range(7, 1)), 8'($urandom), 16'($urandom), 1'($urandom));
      end
      if (bus_shape.ph == PH_ACK_WAIT) begin
        sda = (int'($urandom_range(99)) < hold_pct);
      end else if (bus_shape.ph == PH_RX_SAMPLE && rx_mode != RX_RANDOM) begin
        sda = (rx_mode == RX_ONES);
      end else begin
        sda = 1'($urandom);
      end
      offer(OP_TICK, 8'($urandom), 16'($urandom), sda);
    end
  endtask

  // Writes both configuration registers back to back.
  task automatic write_config(input logic [15:0] dev_word, input logic [15:0] tmo);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DEVICE_ADDRESS;
    cfg_data_i  <= dev_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_dev = dev_word[6:0];
    cfg_index_i <= CFG_ACK_TIMEOUT;
    cfg_data_i  <= tmo;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_tmo = tmo;
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued word is taken and every result has arrived.
  // The check runs on the falling edge, after the driver's updates settle.
  task automatic wait_drained();
    while (bus_words.size() != 0 || in_valid_i || bus_outcomes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (n_mismatch < MAX_PRINTS) begin
      $display("mismatch on result %0d: %s got %h, want %h", n_checked, what, got, want);
    end
    n_mismatch++;
  endtask

  // Driver: predicts each accepted word and presents the next one.
  always @(posedge clk_i) begin : drive_words
    seq_result_t res;
    bus_word_t   w;
    if (!rst_ni) begin
      bus_ref = bus_idle();
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        w.op       = op_i;
        w.reg_addr = reg_addr_i;
        w.wdata    = write_data_i;
        w.sda      = sda_in_i;
        bus_ref    = i2c_next(bus_ref, w, cfg_dev, cfg_tmo, res);
        bus_outcomes.push_back(res);
      end
      if (!in_valid_i || in_ready_o) begin
        if (bus_words.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          w = bus_words.pop_front();
          in_valid_i   <= 1'b1;
          op_i         <= w.op;
          reg_addr_i   <= w.reg_addr;
          write_data_i <= w.wdata;
          sda_in_i     <= w.sda;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    seq_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_checked++;
        if (bus_outcomes.size() == 0) begin
          report_mismatch("result with nothing pending", 16'd1, 16'd0);
        end else begin
          want = bus_outcomes.pop_front();
          if (scl_level_o !== want.scl_level)
            report_mismatch("scl_level", 16'(scl_level_o), 16'(want.scl_level));
          if (sda_level_o !== want.sda_level)
            report_mismatch("sda_level", 16'(sda_level_o), 16'(want.sda_level));
          if (busy_res_o !== want.busy)
            report_mismatch("busy_res", 16'(busy_res_o), 16'(want.busy));
          if (done_res_o !== want.done)
            report_mismatch("done_res", 16'(done_res_o), 16'(want.done));
          if (nack_error_o !== want.nack_error)
            report_mismatch("nack_error", 16'(nack_error_o), 16'(want.nack_error));
          if (read_data_o !== want.read_data)
            report_mismatch("read_data", read_data_o, want.read_data);
        end
      end
      out_ready_i <= (hold_left == 0) && (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, started once after the pressure phase has queued its words.
  always @(posedge clk_i) begin
    if (pressure_mode && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus: directed transfers at the reset settings, then random phases.
  initial begin : stimulus
    int         p;
    logic [6:0] dev;
    logic [15:0] tmo;
    int         hold;
    bus_shape = bus_idle();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle tick and undefined ops leave the bus alone.
    offer(OP_TICK, 8'hFF, 16'hFFFF, 1'b1);
    offer(OP_UNDEF_FIRST, 8'hFF, 16'hFFFF, 1'b0);
    offer(OP_UNDEF_FIRST + 3'd1, 8'h00, 16'h0000, 1'b1);
    offer(OP_UNDEF_LAST, 8'hFF, 16'hFFFF, 1'b1);
    // Every command with prompt ACKs, extreme values and read patterns.
    run_txn(OP_WRITE8, 8'h00, 16'h0000, RX_RANDOM, 0, 0);
    run_txn(OP_WRITE16, 8'hFF, 16'hFFFF, RX_RANDOM, 0, 0);
    run_txn(OP_READ8, 8'hA5, 16'h5AA5, RX_ONES, 0, 0);
    run_txn(OP_READ16, 8'h5A, 16'h0000, RX_ONES, 0, 0);
    run_txn(OP_READ8, 8'hFF, 16'hFFFF, RX_ZEROS, 0, 0);
    // Slow ACKs with commands arriving while busy.
    run_txn(OP_READ16, 8'h3C, 16'hFFFF, RX_ZEROS, 50, 20);
    run_txn(OP_WRITE16, 8'h81, 16'h8001, RX_RANDOM, 30, 20);
    wait_drained();

    for (p = 0; p < PHASE_COUNT; p++) begin
      dev = 7'($urandom);
      tmo = 16'($urandom_range(8, 1));
      case (p)
        0: begin
          dev = 7'h7F;
          tmo = 16'd1;
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          dev = 7'h00;
          tmo = 16'hFFFF;
          send_idle_pct  = 60;
          recv_stall_pct = 0;
        end
        2: begin
          tmo = 16'd2;
          send_idle_pct  = 0;
          recv_stall_pct = 60;
        end
        3: begin
          tmo = 16'd3;
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
        PRESSURE_PHASE: begin
          tmo = 16'd1;
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        5: begin
          send_idle_pct  = 60;
          recv_stall_pct = 0;
        end
        6: begin
          tmo = ACK_TIMEOUT_RESET;
          send_idle_pct  = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
      endcase
      // Upper data bits are junk that the address register must drop.
      write_config({9'($urandom), dev}, tmo);

      n_counted = 0;
      while (n_counted < WORDS_PER_PHASE) begin
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1) == 0) begin
            offer(OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
          end else begin
            offer(3'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST)), 8'($urandom),
                  16'($urandom), 1'($urandom));
          end
        end
        // Mostly prompt ACKs; now and then a device that holds SDA high.
        hold = ($urandom_range(3) == 0) ? 92 : int'($urandom_range(40));
        run_txn(3'($urandom_range(OP_READ16, OP_WRITE8)), 8'($urandom), 16'($urandom),
                RX_RANDOM, hold, 3);
      end
      if (p == PRESSURE_PHASE) begin
        pressure_mode = 1'b1;
      end
      wait_drained();
    end

    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/i2cram_pkg.sv
hdl/i2cram_cfg.sv
hdl/i2cram_seq.sv
hdl/i2c_register_access_master.sv
verif/i2c_register_access_master_test.sv
